// ===== hdl/wmjc_pkg.sv =====
// Shared types and constants for the windowed minimum jump cost block.
package wmjc_pkg;

    localparam int HEIGHT_W = 16;
    localparam int COST_W   = 32;
    localparam int CFG_W    = 8;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [CFG_W-1:0]  JUMP_LIMIT_RST = CFG_W'(2);

    // One stored stone: its height and the least cost to reach it.
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COST_W-1:0]   cost;
    } t_entry;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

endpackage

// ===== hdl/windowed_min_jump_cost_dp_top.sv =====
// Top level of the windowed minimum jump cost block: sequencer, cell chain and output register.
//
// Usage: stone heights enter on the input channel (i_in_valid / o_in_ready) with
// i_start_new marking the first stone of a sequence. Each request yields one
// result, the least total cost to reach that stone, on the output channel
// (o_out_valid / i_out_ready). The jump limit is written on the configuration
// channel (i_cfg_valid / o_cfg_ready), which is always ready.
// The past MAX_JUMP stones sit in a chain of cells. For a stone with history, a
// token carrying the running minimum walks the chain one cell per cycle over
// span = min(stones in this sequence, jump limit) cells. The result then waits in
// the hold state, moves to the output register once that is free, and the block
// returns to idle to take the next request, so a request is not taken before the
// last one's result is registered. A first stone skips the walk.
// Reset empties the history and sets the jump limit to 2; window contents are
// not cleared, since the fill count keeps them from being read.
// A result waits in the output register while the receiver stalls; the next
// request is still taken and worked on, and it waits once its result is ready.
module windowed_min_jump_cost_dp_top
    import wmjc_pkg::*;
#(
    parameter int MAX_JUMP = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [HEIGHT_W-1:0] i_height,
    input  logic                i_start_new,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [COST_W-1:0]   o_min_cost,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_jump_limit
);

    localparam int CNT_W = $clog2(MAX_JUMP + 1);
    localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_jump_limit;
    logic [CNT_W-1:0]    r_filled, n_filled;
    logic [CNT_W-1:0]    r_span, n_span;
    logic                r_start, n_start;
    logic [HEIGHT_W-1:0] r_h;
    logic [COST_W-1:0]   r_best, n_best;
    logic                r_out_valid, n_out_valid;
    logic [COST_W-1:0]   r_out_cost;

    logic                in_acc;
    logic                commit;
    logic [CNT_W-1:0]    eff_filled;
    logic [LW-1:0]       lim_ext;
    logic [CNT_W-1:0]    lim;
    t_entry              new_entry;

    t_entry              w_ent   [MAX_JUMP];
    logic                w_tok   [MAX_JUMP];
    logic [CNT_W-1:0]    w_rem   [MAX_JUMP];
    logic [COST_W-1:0]   w_min   [MAX_JUMP];
    logic [MAX_JUMP-1:0] w_fin;
    logic [MAX_JUMP-1:0] w_tokv;
    logic                chain_fin;
    logic [COST_W-1:0]   chain_min;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign commit      = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);
    assign new_entry   = '{height: r_h, cost: r_best};

    // Effective history length and clamped jump limit for a new request.
    always_comb begin
        eff_filled = i_start_new ? '0 : r_filled;
        lim_ext    = LW'(r_jump_limit);
        if (lim_ext == '0) begin
            lim = CNT_W'(1);
        end else if (lim_ext > LW'(MAX_JUMP)) begin
            lim = CNT_W'(MAX_JUMP);
        end else begin
            lim = lim_ext[CNT_W-1:0];
        end
    end

    // Collect the finishing cell's minimum from the chain.
    always_comb begin
        chain_min = '0;
        for (int k = 0; k < MAX_JUMP; k++) begin
            chain_min = chain_min | (w_fin[k] ? w_min[k] : '0);
            w_tokv[k] = w_tok[k];
        end
        chain_fin = |w_fin;
    end

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_filled    = r_filled;
        n_span      = r_span;
        n_start     = 1'b0;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_filled = eff_filled;
                    if (eff_filled == '0) begin
                        n_best  = '0;
                        n_state = S_HOLD;
                    end else begin
                        n_span  = (eff_filled < lim) ? eff_filled : lim;
                        n_start = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (chain_fin) begin
                    n_best  = chain_min;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (commit) begin
                    n_out_valid = 1'b1;
                    if (r_filled != CNT_W'(MAX_JUMP)) begin
                        n_filled = r_filled + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_filled     <= '0;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_jump_limit <= JUMP_LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_jump_limit <= i_cfg_jump_limit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_span <= n_span;
        r_best <= n_best;
        if (in_acc) begin
            r_h <= i_height;
        end
        if (commit) begin
            r_out_cost <= r_best;
        end
    end

    // Chain of window cells; cell 0 holds the most recent stone.
    for (genvar k = 0; k < MAX_JUMP; k++) begin : g_cell
        if (k == 0) begin : g_head
            wmjc_cell #(.CNT_W(CNT_W)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_shift       (commit),
                .i_entry       (new_entry),
                .o_entry       (w_ent[k]),
                .i_item_height (r_h),
                .i_tok         (r_start),
                .i_rem         (r_span),
                .i_min         (COST_MAX),
                .o_tok         (w_tok[k]),
                .o_rem         (w_rem[k]),
                .o_min         (w_min[k]),
                .o_fin         (w_fin[k])
            );
        end else begin : g_body
            wmjc_cell #(.CNT_W(CNT_W)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_shift       (commit),
                .i_entry       (w_ent[k-1]),
                .o_entry       (w_ent[k]),
                .i_item_height (r_h),
                .i_tok         (w_tok[k-1]),
                .i_rem         (w_rem[k-1]),
                .i_min         (w_min[k-1]),
                .o_tok         (w_tok[k]),
                .o_rem         (w_rem[k]),
                .o_min         (w_min[k]),
                .o_fin         (w_fin[k])
            );
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_min_cost  = r_out_cost;

    // At most one cell finishes a walk at a time.
    a_one_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_fin))
        else $error("more than one cell finished a token walk");

    // A finished walk is only seen while the sequencer waits for it.
    a_fin_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_fin |-> (r_state == S_RUN))
        else $error("token walk finished outside the run state");

    // No token travels the chain while the block is idle or holding a result.
    a_no_tok_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_HOLD) |-> (w_tokv == '0 && !r_start))
        else $error("token in chain outside a run");

    // The history count never exceeds the window.
    a_filled_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(MAX_JUMP))
        else $error("history count above window depth");

endmodule

// ===== hdl/wmjc_cell.sv =====
// One window cell: holds a past stone and folds its jump candidate into a passing minimum.
module wmjc_cell
    import wmjc_pkg::*;
#(
    parameter int CNT_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  t_entry              i_entry,
    output t_entry              o_entry,
    input  logic [HEIGHT_W-1:0] i_item_height,
    input  logic                i_tok,
    input  logic [CNT_W-1:0]    i_rem,
    input  logic [COST_W-1:0]   i_min,
    output logic                o_tok,
    output logic [CNT_W-1:0]    o_rem,
    output logic [COST_W-1:0]   o_min,
    output logic                o_fin
);

    t_entry              r_entry;
    logic                r_tok;
    logic                r_fin;
    logic [CNT_W-1:0]    r_rem;
    logic [COST_W-1:0]   r_min;

    logic [HEIGHT_W-1:0] diff;
    logic [COST_W:0]     sum;
    logic [COST_W-1:0]   cand;
    logic [COST_W-1:0]   n_min;
    logic                last;

    // Candidate cost of jumping from this stone, saturated, then the running minimum.
    always_comb begin
        if (i_item_height >= r_entry.height) begin
            diff = i_item_height - r_entry.height;
        end else begin
            diff = r_entry.height - i_item_height;
        end
        sum   = {1'b0, r_entry.cost} + {{(COST_W + 1 - HEIGHT_W){1'b0}}, diff};
        cand  = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        n_min = (cand < i_min) ? cand : i_min;
        last  = (i_rem == CNT_W'(1));
    end

    // Token control: it moves on to the neighbor or stops here as the final result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_tok <= i_tok && !last;
            r_fin <= i_tok && last;
        end
    end

    // Token payload and stored stone.
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_min <= n_min;
            r_rem <= i_rem - CNT_W'(1);
        end
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;
    assign o_rem   = r_rem;
    assign o_min   = r_min;
    assign o_fin   = r_fin;

endmodule

// ===== tb/sv/wmjc_cost_checker.sv =====
// Checker for the windowed minimum jump cost block: predicts each stone's cost and compares.
`timescale 1ns / 100ps

module wmjc_cost_checker
    import wmjc_pkg::*;
#(
    parameter int WINDOW = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [HEIGHT_W-1:0] i_height,
    input  logic                i_start_new,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [COST_W-1:0]   i_min_cost,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_jump_limit,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int REPORT_MAX = 10;

    // Recent stones of the current sequence, index 0 is the newest.
    logic [HEIGHT_W-1:0] hist_height [0:WINDOW-1];
    logic [COST_W-1:0]   hist_cost   [0:WINDOW-1];
    int unsigned         hist_fill;
    logic [CFG_W-1:0]    jump_cfg;

    // Costs predicted for requests whose results have not come yet.
    logic [COST_W-1:0]   cost_q [$];

    // Least cost to reach a new stone; pushes the stone into the history.
    function automatic logic [COST_W-1:0] reach_cost(input logic [HEIGHT_W-1:0] h,
                                                     input logic fresh);
        int unsigned         lim;
        int unsigned         span;
        int unsigned         d;
        logic [COST_W:0]     cand;
        logic [HEIGHT_W-1:0] diff;
        logic [COST_W-1:0]   best;

        if (fresh) begin
            hist_fill = 0;
        end
        // A limit of zero behaves as one, and the window bounds the top end.
        lim = jump_cfg;
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > WINDOW) begin
            lim = WINDOW;
        end

        if (hist_fill == 0) begin
            best = '0;
        end else begin
            span = (hist_fill < lim) ? hist_fill : lim;
            best = COST_MAX;
            for (d = 0; d < span; d++) begin
                diff = (h >= hist_height[d]) ? h - hist_height[d] : hist_height[d] - h;
                cand = {1'b0, hist_cost[d]} + (COST_W + 1)'(diff);
                if (cand > {1'b0, COST_MAX}) begin
                    cand = {1'b0, COST_MAX};
                end
                if (cand[COST_W-1:0] < best) begin
                    best = cand[COST_W-1:0];
                end
            end
        end

        for (d = WINDOW - 1; d > 0; d--) begin
            hist_height[d] = hist_height[d-1];
            hist_cost[d]   = hist_cost[d-1];
        end
        hist_height[0] = h;
        hist_cost[0]   = best;
        if (hist_fill < WINDOW) begin
            hist_fill++;
        end
        return best;
    endfunction

    // Track configuration and requests, then check each result in order.
    always @(posedge i_clk) begin
        logic [COST_W-1:0] want;

        if (!i_rst_n) begin
            cost_q.delete();
            hist_fill = 0;
            jump_cfg  = JUMP_LIMIT_RST;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                jump_cfg = i_cfg_jump_limit;
            end
            if (i_in_valid && i_in_ready) begin
                cost_q.push_back(reach_cost(i_height, i_start_new));
            end
            if (i_out_valid && i_out_ready) begin
                if (cost_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX) begin
                        $display("%0t: result with no request outstanding: min_cost 0x%08h",
                                 $time, i_min_cost);
                    end
                end else begin
                    want = cost_q.pop_front();
                    if (i_min_cost !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("%0t: min_cost mismatch: expected 0x%08h, got 0x%08h",
                                     $time, want, i_min_cost);
                        end
                    end
                end
            end
            o_pending <= cost_q.size();
        end
    end

endmodule

// ===== tb/sv/windowed_min_jump_cost_dp_top_test.sv =====
// Testbench top for the windowed minimum jump cost block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module windowed_min_jump_cost_dp_top_test;
    import wmjc_pkg::*;

    localparam int MAX_JUMP    = 128;
    localparam int QUIET_LIMIT = 2000;
    localparam int RUN_LEN     = 24;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SOME
    } t_idle_mode;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [HEIGHT_W-1:0] i_height         = '0;
    logic                i_start_new      = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    logic [COST_W-1:0]   o_min_cost;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_jump_limit = '0;

    int                  fail_count;
    int                  pending;
    int                  quiet_cycles     = 0;
    int                  out_stall        = 0;
    t_idle_mode          in_idle          = IDLE_NONE;
    t_idle_mode          out_idle         = IDLE_NONE;
    logic [HEIGHT_W-1:0] last_height      = '0;

    windowed_min_jump_cost_dp_top #(
        .MAX_JUMP(MAX_JUMP)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_height        (i_height),
        .i_start_new     (i_start_new),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_min_cost      (o_min_cost),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_jump_limit(i_cfg_jump_limit)
    );

    wmjc_cost_checker #(
        .WINDOW(MAX_JUMP)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_height        (i_height),
        .i_start_new     (i_start_new),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_min_cost      (o_min_cost),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_jump_limit(i_cfg_jump_limit),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Free-running clock with a 10 ns period.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Number of cycles a side holds off before its next request.
    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_FULL: return $urandom_range(0, 17);
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
            default:   return 0;
        endcase
    endfunction

    // Receiver: after each result it takes, it may stall for a drawn number of cycles.
    always @(posedge i_clk) begin
        int n;

        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else if (i_out_ready && o_out_valid) begin
            n = draw_wait(out_idle);
            out_stall   <= n;
            i_out_ready <= (n == 0);
        end else if (!i_out_ready) begin
            if (out_stall <= 1) begin
                i_out_ready <= 1'b1;
            end else begin
                out_stall <= out_stall - 1;
            end
        end
    end

    // Watchdog: ends the run when no channel has moved a request for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("windowed_min_jump_cost_dp_top_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one stone after the sender's drawn gap and wait until it is taken.
    task automatic send_stone(input logic [HEIGHT_W-1:0] h, input logic fresh);
        int gap;

        gap = draw_wait(in_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_height    <= h;
        i_start_new <= fresh;
        last_height = h;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted cost has been returned.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write the jump limit; only called while the block is idle.
    task automatic write_jump_limit(input logic [CFG_W-1:0] value);
        i_cfg_valid      <= 1'b1;
        i_cfg_jump_limit <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: new limit, then sequences of random stones.
    task automatic run_phase(input logic [CFG_W-1:0] lim, input int count,
                             input int start_pct);
        int                  n;
        logic                fresh;
        logic [HEIGHT_W-1:0] h;

        drain_results();
        write_jump_limit(lim);
        in_idle  = t_idle_mode'($urandom_range(0, 2));
        out_idle = t_idle_mode'($urandom_range(0, 2));
        for (n = 0; n < count; n++) begin
            fresh = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < start_pct);
            case ($urandom_range(0, 3))
                0, 1:    h = HEIGHT_W'($urandom_range(0, 65535));
                2:       h = $urandom_range(0, 1) ? '1 : '0;
                default: h = last_height + HEIGHT_W'($urandom_range(0, 64)) - HEIGHT_W'(32);
            endcase
            send_stone(h, fresh);
            // Now and then the sender holds back until all results are home.
            if ($urandom_range(0, 59) == 0) begin
                drain_results();
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first stone right after reset without a start flag costs nothing.
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h0000, 1'b0);
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h5555, 1'b0);
        // A new sequence must ignore every older stone.
        send_stone(16'h8000, 1'b1);
        send_stone(16'hAAAA, 1'b0);
        send_stone(16'h5555, 1'b0);
        send_stone(16'h0001, 1'b1);
        send_stone(16'hFFFE, 1'b0);
        send_stone(16'h0000, 1'b0);
        send_stone(16'h0000, 1'b1);

        // A zero limit behaves as a limit of one.
        drain_results();
        write_jump_limit(8'd0);
        send_stone(16'h1234, 1'b1);
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h1234, 1'b0);
        send_stone(16'h0000, 1'b0);

        // A limit beyond the window is clipped to the window.
        drain_results();
        write_jump_limit(8'd255);
        send_stone(16'h0000, 1'b1);
        send_stone(16'hFFFF, 1'b0);
        send_stone(16'h00FF, 1'b0);
        send_stone(16'hFF00, 1'b0);
        send_stone(16'h0000, 1'b0);

        // Zigzag with a limit of one adds the full height range at every step.
        drain_results();
        write_jump_limit(8'd1);
        send_stone(16'h0000, 1'b1);
        for (n = 1; n <= RUN_LEN; n++) begin
            send_stone((n % 2) ? 16'hFFFF : 16'h0000, 1'b0);
        end

        // Random phases over a spread of limits, extremes included.
        run_phase(8'd0, 45, 8);
        run_phase(8'd1, 45, 10);
        run_phase(8'd3, 45, 15);
        run_phase(8'd5, 45, 5);
        run_phase(8'd17, 45, 4);
        run_phase(8'd64, 45, 3);
        run_phase(8'd128, 100, 0);
        run_phase(8'd127, 45, 6);
        run_phase(8'd129, 45, 2);
        run_phase(8'd255, 100, 1);
        run_phase(8'($urandom_range(0, 255)), 45, 10);

        drain_results();
        repeat (MAX_JUMP + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("windowed_min_jump_cost_dp_top_test: PASS");
        end else begin
            $display("windowed_min_jump_cost_dp_top_test: FAIL");
        end
        $finish;
    end

endmodule
